FILE: hw/rtl/jspd_pkg.sv
// Shared types, constants and helpers of the joint servo PD command block.
`timescale 1ns / 1ps

package jspd_pkg;

  localparam int NUM_JOINTS = 6;
  localparam int JOINT_W    = 3;
  localparam int DIV_W      = 49;
  localparam int DEN_W      = 31;

  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_REACH  = 2'd1;
  localparam logic [1:0] CFG_GAIN_P = 2'd2;
  localparam logic [1:0] CFG_GAIN_D = 2'd3;

  localparam logic FUNC_PRESET = 1'b0;
  localparam logic FUNC_STEP   = 1'b1;

  typedef struct packed {
    logic               func;
    logic [JOINT_W-1:0] joint;
    logic signed [31:0] target;
    logic [30:0]        period;
  } req_t;

  typedef struct packed {
    logic [JOINT_W-1:0] out_joint;
    logic signed [31:0] cmd_position;
    logic signed [31:0] cmd_velocity;
    logic signed [31:0] cmd_accel;
  } rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (v > 51'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -51'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/joint_servo_pd_command.sv
// Top level of the per-joint PD servo command generator.
// Usage:
// A request on the input channel names a joint, a target angle and a period dt.
// A preset request loads the joint's commanded position and gives no result.
// A step request, while enabled and with nonzero dt, gives one result with the
// joint, the new position, the velocity and the acceleration in Q16.16.
// The configuration channel writes enable, reach time and the two gains; it
// is always ready. The user must see that it is written only while the block
// is idle; the block itself does not enforce this. A step passes a memory read,
// two divisions in a shared serial divider and three multiplies on one shared
// multiplier, then raises out_valid_o. Presets and ignored requests leave the
// block idle and ready. One request is worked on at a time.
// The result waits in an output register; a new request is taken while it
// waits, and a finished step holds until the register is free.
// Reset clears the configuration to its defaults and marks every joint's
// stored position and velocity as zero through per-entry valid bits.
`timescale 1ns / 1ps

module joint_servo_pd_command (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  jspd_pkg::req_t   in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output jspd_pkg::rsp_t   out_rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_MP   = 3'd3;
  localparam logic [2:0] S_MD   = 3'd4;
  localparam logic [2:0] S_VEL  = 3'd5;
  localparam logic [2:0] S_DIV2 = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]  state_q, state_d;
  logic        en_q;
  logic [30:0] rt_q, gp_q, gd_q;

  logic signed [31:0] cp_mem [jspd_pkg::NUM_JOINTS];
  logic signed [31:0] pv_mem [jspd_pkg::NUM_JOINTS];
  logic [jspd_pkg::NUM_JOINTS-1:0] cp_vld_q, pv_vld_q;
  logic signed [31:0] cp_rd_q, pv_rd_q;
  logic               cp_rv_q, pv_rv_q;

  jspd_pkg::req_t     item_q;
  jspd_pkg::rsp_t     out_q;
  logic               out_valid_q;
  logic signed [31:0] cp_q, pv_q, vel_q;
  logic signed [32:0] e_q, ed_q;
  logic               neg_q;
  logic signed [65:0] prod_q, sum_q;
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;

  logic                        accept, in_range, done_fire;
  logic                        div_start, div_busy;
  logic [jspd_pkg::DIV_W-1:0]  div_dvd, div_quo;
  logic [jspd_pkg::DEN_W-1:0]  div_den;

  logic signed [31:0] cp_cur, pv_cur, ref_vel, vel_new, acc_new, pos_new;
  logic signed [32:0] e_cur, dv;
  logic [32:0]        e_abs, dv_abs;
  logic [49:0]        e_scaled;
  logic signed [50:0] q_signed;
  logic signed [65:0] vel_sum;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign in_range    = 32'(in_req_i.joint) < 32'(jspd_pkg::NUM_JOINTS);
  assign done_fire   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
      rt_q <= 31'd2163;
      gp_q <= 31'd65536;
      gd_q <= 31'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        jspd_pkg::CFG_ENABLE: en_q <= cfg_data_i[0];
        jspd_pkg::CFG_REACH:  rt_q <= cfg_data_i[30:0];
        jspd_pkg::CFG_GAIN_P: gp_q <= cfg_data_i[30:0];
        jspd_pkg::CFG_GAIN_D: gd_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_range) begin
      cp_rd_q <= cp_mem[in_req_i.joint];
      pv_rd_q <= pv_mem[in_req_i.joint];
    end
    if (accept && in_range && in_req_i.func == jspd_pkg::FUNC_PRESET) begin
      cp_mem[in_req_i.joint] <= in_req_i.target;
    end else if (done_fire) begin
      cp_mem[item_q.joint] <= pos_new;
    end
    if (done_fire) begin
      pv_mem[item_q.joint] <= vel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_vld_q <= '0;
      pv_vld_q <= '0;
      cp_rv_q  <= 1'b0;
      pv_rv_q  <= 1'b0;
    end else begin
      if (accept && in_range) begin
        cp_rv_q <= cp_vld_q[in_req_i.joint];
        pv_rv_q <= pv_vld_q[in_req_i.joint];
      end
      if (accept && in_range && in_req_i.func == jspd_pkg::FUNC_PRESET) begin
        cp_vld_q[in_req_i.joint] <= 1'b1;
      end else if (done_fire) begin
        cp_vld_q[item_q.joint] <= 1'b1;
      end
      if (done_fire) begin
        pv_vld_q[item_q.joint] <= 1'b1;
      end
    end
  end

  always_comb begin
    cp_cur   = cp_rv_q ? cp_rd_q : 32'sd0;
    pv_cur   = pv_rv_q ? pv_rd_q : 32'sd0;
    e_cur    = 33'(item_q.target) - 33'(cp_cur);
    e_abs    = e_cur[32] ? 33'(-e_cur) : e_cur;
    e_scaled = ({17'd0, e_abs} << 17) - ({17'd0, e_abs} << 13);
    q_signed = neg_q ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    ref_vel  = jspd_pkg::sat32(q_signed);
    vel_sum  = sum_q + prod_q;
    vel_new  = jspd_pkg::sat32({vel_sum[65], vel_sum[65:16]});
    dv       = 33'(vel_new) - 33'(pv_q);
    dv_abs   = dv[32] ? 33'(-dv) : dv;
    acc_new  = ref_vel;
    pos_new  = jspd_pkg::sat32({prod_q[65], prod_q[65:16]} + 51'(cp_q));
  end

  always_comb begin
    unique case (state_q)
      S_MP: begin
        mul_a = {e_q[32], e_q};
        mul_b = {1'b0, gp_q};
      end
      S_MD: begin
        mul_a = {ed_q[32], ed_q};
        mul_b = {1'b0, gd_q};
      end
      default: begin
        mul_a = 34'(vel_q);
        mul_b = {1'b0, item_q.period};
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_dvd   = e_scaled[jspd_pkg::DIV_W-1:0];
    div_den   = (rt_q == 31'd0) ? 31'd1 : rt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && in_range && in_req_i.func != jspd_pkg::FUNC_PRESET && en_q
            && in_req_i.period != 31'd0) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        div_start = 1'b1;
        state_d   = S_DIV1;
      end
      S_DIV1: begin
        if (!div_busy) begin
          state_d = S_MP;
        end
      end
      S_MP:  state_d = S_MD;
      S_MD:  state_d = S_VEL;
      S_VEL: begin
        div_start = 1'b1;
        div_dvd   = {dv_abs[31:0], 16'd0, 1'b0} >> 1;
        div_den   = item_q.period;
        state_d   = S_DIV2;
      end
      S_DIV2: begin
        if (!div_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (done_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (accept) begin
      item_q <= in_req_i;
    end
    if (state_q == S_RD) begin
      cp_q  <= cp_cur;
      pv_q  <= pv_cur;
      e_q   <= e_cur;
      neg_q <= e_cur[32];
    end
    if (state_q == S_DIV1 && !div_busy) begin
      ed_q <= 33'(ref_vel) - 33'(pv_q);
    end
    if (state_q == S_MD) begin
      sum_q <= prod_q;
    end
    if (state_q == S_VEL) begin
      vel_q <= vel_new;
      neg_q <= dv[32];
    end
    if (done_fire) begin
      out_q.out_joint    <= item_q.joint;
      out_q.cmd_position <= pos_new;
      out_q.cmd_velocity <= vel_q;
      out_q.cmd_accel    <= acc_new;
    end
  end

  jspd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

FILE: hw/rtl/jspd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module jspd_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [jspd_pkg::DIV_W-1:0]  dividend_i,
  input  logic [jspd_pkg::DEN_W-1:0]  divisor_i,
  output logic                        busy_o,
  output logic [jspd_pkg::DIV_W-1:0]  quotient_o
);

  logic                       busy_q, busy_d;
  logic [5:0]                 cnt_q, cnt_d;
  logic [jspd_pkg::DEN_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [jspd_pkg::DIV_W-1:0] quo_q, quo_d;
  logic [jspd_pkg::DEN_W:0]   trial;
  logic                       ge;

  always_comb begin
    trial  = {rem_q, quo_q[jspd_pkg::DIV_W-1]};
    ge     = trial >= {1'b0, den_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'(jspd_pkg::DIV_W);
      rem_d  = '0;
      den_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? 31'(trial - {1'b0, den_q}) : trial[jspd_pkg::DEN_W-1:0];
      quo_d = {quo_q[jspd_pkg::DIV_W-2:0], ge};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

FILE: bench/jspd_checker.sv
// Checker for the joint servo PD command block: predicts every result and compares it.
`timescale 1ns / 1ps

module jspd_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  jspd_pkg::req_t  in_req_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  jspd_pkg::rsp_t  out_rsp_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [31:0]     cfg_data_i,
  output int              fail_count_o,
  output int              pending_o
);

  typedef logic signed [95:0] wide_t;

  logic               enable_q;
  logic [30:0]        reach_q;
  logic [30:0]        kp_q;
  logic [30:0]        kd_q;
  logic signed [31:0] cmd_pos_q [jspd_pkg::NUM_JOINTS];
  logic signed [31:0] last_vel_q [jspd_pkg::NUM_JOINTS];
  jspd_pkg::rsp_t     cmd_queue [$];
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = cmd_queue.size();

  function automatic logic signed [31:0] clamp32(input wide_t v);
    if (v > wide_t'(64'sd2147483647)) return 32'sh7fffffff;
    if (v < wide_t'(-64'sd2147483648)) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic servo_step(input jspd_pkg::req_t r);
    wide_t          e, t, rv, ed, v, dv, dt;
    jspd_pkg::rsp_t c;
    logic [2:0]     j;
    j  = r.joint;
    t  = (reach_q == 31'd0) ? wide_t'(1) : wide_t'({65'b0, reach_q});
    dt = wide_t'({65'b0, r.period});
    e  = wide_t'(r.target) - wide_t'(cmd_pos_q[j]);
    rv = wide_t'(clamp32((e * 122880) / t));
    ed = rv - wide_t'(last_vel_q[j]);
    v  = wide_t'(clamp32((e * wide_t'({65'b0, kp_q}) + ed * wide_t'({65'b0, kd_q})) >>> 16));
    dv = v - wide_t'(last_vel_q[j]);
    c.out_joint    = r.joint;
    c.cmd_velocity = v[31:0];
    c.cmd_accel    = clamp32((dv * 65536) / dt);
    c.cmd_position = clamp32(wide_t'(cmd_pos_q[j]) + ((v * dt) >>> 16));
    cmd_pos_q[j]  = c.cmd_position;
    last_vel_q[j] = c.cmd_velocity;
    cmd_queue.push_back(c);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    jspd_pkg::rsp_t exp_cmd;
    if (!rst_ni) begin
      enable_q <= 1'b0;
      reach_q  <= 31'd2163;
      kp_q     <= 31'd65536;
      kd_q     <= 31'd0;
      fails    <= 0;
      cmd_queue.delete();
      for (int i = 0; i < jspd_pkg::NUM_JOINTS; i++) begin
        cmd_pos_q[i]  = '0;
        last_vel_q[i] = '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          jspd_pkg::CFG_ENABLE: enable_q <= cfg_data_i[0];
          jspd_pkg::CFG_REACH:  reach_q  <= cfg_data_i[30:0];
          jspd_pkg::CFG_GAIN_P: kp_q     <= cfg_data_i[30:0];
          jspd_pkg::CFG_GAIN_D: kd_q     <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i && 32'(in_req_i.joint) < jspd_pkg::NUM_JOINTS) begin
        if (in_req_i.func == jspd_pkg::FUNC_PRESET) begin
          cmd_pos_q[in_req_i.joint] = in_req_i.target;
        end else if (enable_q && in_req_i.period != 31'd0) begin
          servo_step(in_req_i);
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (cmd_queue.size() == 0) begin
          $error("unexpected result for joint %0d", out_rsp_i.out_joint);
          fails <= fails + 1;
        end else begin
          exp_cmd = cmd_queue.pop_front();
          if (out_rsp_i !== exp_cmd) begin
            fails <= fails + 1;
            if (out_rsp_i.out_joint !== exp_cmd.out_joint)
              $error("out_joint: expected %0d, got %0d", exp_cmd.out_joint,
                     out_rsp_i.out_joint);
            if (out_rsp_i.cmd_position !== exp_cmd.cmd_position)
              $error("cmd_position: expected %0d, got %0d", exp_cmd.cmd_position,
                     out_rsp_i.cmd_position);
            if (out_rsp_i.cmd_velocity !== exp_cmd.cmd_velocity)
              $error("cmd_velocity: expected %0d, got %0d", exp_cmd.cmd_velocity,
                     out_rsp_i.cmd_velocity);
            if (out_rsp_i.cmd_accel !== exp_cmd.cmd_accel)
              $error("cmd_accel: expected %0d, got %0d", exp_cmd.cmd_accel,
                     out_rsp_i.cmd_accel);
          end
        end
      end
    end
  end

endmodule

FILE: bench/tb_joint_servo_pd_command.sv
// Testbench top of the joint servo PD command block: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_joint_servo_pd_command;

  localparam int STALL_LIMIT = 5000;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  jspd_pkg::req_t in_req = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  jspd_pkg::rsp_t out_rsp;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [1:0]     cfg_index = jspd_pkg::CFG_ENABLE;
  logic [31:0]    cfg_data = '0;
  int             fail_count;
  int             pending;
  logic           no_gaps = 1'b0;
  int             idle_cycles = 0;
  int             hold_cnt = 0;

  always #2 clk = ~clk;

  joint_servo_pd_command u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_rsp_o(out_rsp),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  jspd_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_req_i(in_req),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_rsp_i(out_rsp),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // The receiver stalls at random after each result it takes, except while no_gaps is set.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        hold_cnt = no_gaps ? 0 : int'($urandom_range(0, 14));
        out_ready <= (hold_cnt == 0);
      end else if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= (hold_cnt == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (in_valid && in_ready || out_valid && out_ready || cfg_valid && cfg_ready) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_request(input logic func, input logic [2:0] joint,
                              input logic [31:0] target, input logic [30:0] period);
    int gap;
    gap = no_gaps ? 0 : int'($urandom_range(0, 14));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req.func   <= func;
    in_req.joint  <= joint;
    in_req.target <= target;
    in_req.period <= period;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (130) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_request();
    logic [30:0] dt;
    logic [31:0] tgt;
    int          pick;
    pick = int'($urandom_range(0, 99));
    case ($urandom_range(0, 5))
      0:       dt = 31'($urandom());
      1:       dt = $urandom_range(0, 3) == 0 ? 31'h7fffffff : 31'd0;
      default: dt = 31'($urandom_range(1, 6554));
    endcase
    tgt = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 400000) - 200000;
    if (pick < 15) begin
      send_request(jspd_pkg::FUNC_PRESET, 3'($urandom_range(0, 5)), tgt, 31'($urandom()));
    end else if (pick < 20) begin
      send_request(1'($urandom()), 3'($urandom_range(6, 7)), $urandom(), 31'($urandom()));
    end else begin
      send_request(jspd_pkg::FUNC_STEP, 3'($urandom_range(0, 5)), tgt, dt);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Disabled steps, presets and ignored joints.
    send_request(jspd_pkg::FUNC_STEP, 3'd0, 32'h00010000, 31'd655);
    send_request(jspd_pkg::FUNC_PRESET, 3'd1, 32'h7fffffff, 31'h7fffffff);
    send_request(jspd_pkg::FUNC_PRESET, 3'd2, 32'h80000000, 31'd0);
    send_request(jspd_pkg::FUNC_PRESET, 3'd6, 32'h12345678, 31'd1);
    write_reg(jspd_pkg::CFG_ENABLE, 32'hffff_ffff);
    send_request(jspd_pkg::FUNC_STEP, 3'd1, 32'h80000000, 31'h7fffffff);
    send_request(jspd_pkg::FUNC_STEP, 3'd2, 32'h7fffffff, 31'd1);
    send_request(jspd_pkg::FUNC_STEP, 3'd3, 32'h00020000, 31'd0);
    send_request(jspd_pkg::FUNC_STEP, 3'd7, 32'h00020000, 31'd655);
    send_request(jspd_pkg::FUNC_STEP, 3'd5, 32'h00008000, 31'd655);
    send_request(jspd_pkg::FUNC_STEP, 3'd5, 32'hffff0000, 31'd655);
    write_reg(jspd_pkg::CFG_REACH, 32'h0);
    write_reg(jspd_pkg::CFG_GAIN_D, 32'hffff_ffff);
    send_request(jspd_pkg::FUNC_STEP, 3'd0, 32'h7fffffff, 31'd65);
    send_request(jspd_pkg::FUNC_STEP, 3'd4, 32'h80000000, 31'h7fffffff);
    write_reg(jspd_pkg::CFG_GAIN_P, 32'h7fffffff);
    write_reg(jspd_pkg::CFG_REACH, 32'h7fffffff);
    send_request(jspd_pkg::FUNC_STEP, 3'd0, 32'h80000000, 31'd1);
    send_request(jspd_pkg::FUNC_STEP, 3'd4, 32'h7fffffff, 31'd2);
    write_reg(jspd_pkg::CFG_GAIN_P, 32'h0);
    write_reg(jspd_pkg::CFG_GAIN_D, 32'h0);
    send_request(jspd_pkg::FUNC_STEP, 3'd3, 32'h1234, 31'd100);
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(jspd_pkg::CFG_ENABLE, 32'(ph != 2));
      write_reg(jspd_pkg::CFG_REACH,
                ph == 1 ? 32'd1 : (ph == 4 ? $urandom() : $urandom_range(600, 20000)));
      write_reg(jspd_pkg::CFG_GAIN_P, ph == 3 ? 32'h7fffffff : $urandom_range(0, 200000));
      write_reg(jspd_pkg::CFG_GAIN_D, ph == 5 ? $urandom() : $urandom_range(0, 80000));
      for (int n = 0; n < 225; n++) begin
        if (n % 60 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        random_request();
      end
    end
    in_valid <= 1'b0;
    no_gaps = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
